// File: hw/rtl/rre_pkg.sv
// Shared types, register indexes and constants for the RRE rectangle decoder.
// No dependencies; every other file of the decoder imports this package.
package rre_pkg;

  // Configuration register indexes on the write port.
  localparam logic [2:0] REG_PIXEL_SIZE  = 3'd0;
  localparam logic [2:0] REG_MSB_FIRST   = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd3;
  localparam logic [2:0] REG_AREA_WIDTH  = 3'd4;
  localparam logic [2:0] REG_AREA_HEIGHT = 3'd5;

  // Pixel size codes.
  localparam logic [1:0] PSIZE_ONE  = 2'd0;
  localparam logic [1:0] PSIZE_TWO  = 2'd1;
  localparam logic [1:0] PSIZE_FOUR = 2'd2;

  // Byte counts of the count field and of the subrectangle geometry.
  localparam logic [4:0] COUNT_BYTES = 5'd4;
  localparam logic [4:0] GEOM_BYTES  = 5'd8;

  // Current configuration as seen by the parser.
  typedef struct packed {
    logic [1:0]  pixel_size_code;
    logic        pixel_msb_first;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] area_width;
    logic [15:0] area_height;
  } cfg_t;

  // One fill-box command.
  typedef struct packed {
    logic [16:0] box_x;
    logic [16:0] box_y;
    logic [15:0] box_w;
    logic [15:0] box_h;
    logic [31:0] box_color;
    logic        is_background;
    logic        last_box;
  } box_t;

  // Bytes per pixel for a size code; the unused code means four bytes.
  function automatic logic [4:0] pixel_bytes(input logic [1:0] code);
    logic [4:0] n;
    case (code)
      PSIZE_ONE: n = 5'd1;
      PSIZE_TWO: n = 5'd2;
      default:   n = 5'd4;
    endcase
    return n;
  endfunction

  // Keep only the bytes of the current pixel size.
  function automatic logic [31:0] pixel_mask(input logic [1:0] code, input logic [31:0] v);
    logic [31:0] m;
    case (code)
      PSIZE_ONE: m = {24'd0, v[7:0]};
      PSIZE_TWO: m = {16'd0, v[15:0]};
      default:   m = v;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/rre_cfg_regs.sv
// Configuration register file of the RRE rectangle decoder.
// Depends on rre_pkg for the register indexes and the cfg_t type.
module rre_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output rre_pkg::cfg_t cfg
);
  import rre_pkg::*;

  cfg_t regs;

  // Writes are registered; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pixel_size_code <= PSIZE_FOUR;
      regs.pixel_msb_first <= 1'b0;
      regs.origin_x        <= '0;
      regs.origin_y        <= '0;
      regs.area_width      <= '0;
      regs.area_height     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PIXEL_SIZE:  regs.pixel_size_code <= cfg_data[1:0];
        REG_MSB_FIRST:   regs.pixel_msb_first <= cfg_data[0];
        REG_ORIGIN_X:    regs.origin_x        <= cfg_data;
        REG_ORIGIN_Y:    regs.origin_y        <= cfg_data;
        REG_AREA_WIDTH:  regs.area_width      <= cfg_data;
        REG_AREA_HEIGHT: regs.area_height     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: hw/rtl/rre_parser.sv
// Byte parser of the RRE payload: count, background pixel, subrectangles.
// Depends on rre_pkg for cfg_t, box_t and the pixel helpers.
module rre_parser (
  input  logic          clk,
  input  logic          rst,
  input  rre_pkg::cfg_t cfg,
  input  logic          take,
  input  logic [7:0]    stream_byte,
  output logic          emit,
  output rre_pkg::box_t box
);
  import rre_pkg::*;

  typedef enum logic [1:0] {
    PH_COUNT      = 2'd0,
    PH_BACKGROUND = 2'd1,
    PH_SUBRECT    = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [31:0] remaining, remaining_next;
  logic [31:0] pixel, pixel_next;
  logic [63:0] geom, geom_next;

  logic [4:0]  psize;
  logic [4:0]  idx_inc;
  logic [31:0] pix_shift;
  logic [31:0] pix_g;
  logic [63:0] geom_g;
  logic [31:0] rem_dec;
  logic        done;
  logic        last;

  // Pixel byte merge in either byte order.
  always_comb begin
    if (cfg.pixel_msb_first) begin
      pix_shift = {pixel[23:0], stream_byte};
    end else begin
      case (byte_index[1:0])
        2'd0:    pix_shift = pixel | {24'd0, stream_byte};
        2'd1:    pix_shift = pixel | {16'd0, stream_byte, 8'd0};
        2'd2:    pix_shift = pixel | {8'd0, stream_byte, 16'd0};
        default: pix_shift = pixel | {stream_byte, 24'd0};
      endcase
    end
  end

  assign psize   = pixel_bytes(cfg.pixel_size_code);
  assign idx_inc = {1'b0, byte_index} + 5'd1;
  assign rem_dec = remaining - 32'd1;

  // Next parser state and the box that this byte completes, if any.
  always_comb begin
    phase_next      = phase;
    byte_index_next = idx_inc[3:0];
    remaining_next  = remaining;
    pixel_next      = pixel;
    geom_next       = geom;
    pix_g           = pixel;
    geom_g          = geom;
    done            = 1'b0;
    last            = 1'b0;
    emit            = 1'b0;
    box             = '0;
    case (phase)
      PH_BACKGROUND: begin
        pix_g = pix_shift;
        done  = idx_inc >= psize;
        last  = remaining == 32'd0;
        box.box_x         = {1'b0, cfg.origin_x};
        box.box_y         = {1'b0, cfg.origin_y};
        box.box_w         = cfg.area_width;
        box.box_h         = cfg.area_height;
        box.box_color     = pixel_mask(cfg.pixel_size_code, pix_g);
        box.is_background = 1'b1;
        box.last_box      = last;
        if (done) begin
          emit            = 1'b1;
          byte_index_next = '0;
          phase_next      = last ? PH_COUNT : PH_SUBRECT;
          pixel_next      = '0;
          geom_next       = '0;
        end else begin
          pixel_next = pix_g;
        end
      end
      PH_SUBRECT: begin
        if ({1'b0, byte_index} < psize) begin
          pix_g = pix_shift;
        end else begin
          geom_g = {geom[55:0], stream_byte};
        end
        done = idx_inc >= (psize + GEOM_BYTES);
        last = rem_dec == 32'd0;
        box.box_x         = {1'b0, cfg.origin_x} + {1'b0, geom_g[63:48]};
        box.box_y         = {1'b0, cfg.origin_y} + {1'b0, geom_g[47:32]};
        box.box_w         = geom_g[31:16];
        box.box_h         = geom_g[15:0];
        box.box_color     = pixel_mask(cfg.pixel_size_code, pix_g);
        box.is_background = 1'b0;
        box.last_box      = last;
        if (done) begin
          emit            = 1'b1;
          byte_index_next = '0;
          remaining_next  = rem_dec;
          pixel_next      = '0;
          geom_next       = '0;
          if (last) begin
            phase_next = PH_COUNT;
          end
        end else begin
          pixel_next = pix_g;
          geom_next  = geom_g;
        end
      end
      default: begin
        // Count bytes; the unused phase code behaves the same way.
        remaining_next = {remaining[23:0], stream_byte};
        if (idx_inc >= COUNT_BYTES) begin
          byte_index_next = '0;
          phase_next      = PH_BACKGROUND;
          pixel_next      = '0;
        end
      end
    endcase
  end

  // Parser state advances on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_COUNT;
      byte_index <= '0;
      remaining  <= '0;
      pixel      <= '0;
      geom       <= '0;
    end else if (take) begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      remaining  <= remaining_next;
      pixel      <= pixel_next;
      geom       <= geom_next;
    end
  end

endmodule

// File: hw/rtl/rre_out_reg.sv
// Result register of the RRE decoder with its valid/ready handshake.
// Depends on rre_pkg for the box_t type.
module rre_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  rre_pkg::box_t box_in,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output rre_pkg::box_t box_out
);
  import rre_pkg::*;

  logic full;
  box_t held;

  // The register can take a new box when empty or being drained now.
  assign free = !full || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      if (full && out_ready) begin
        full <= 1'b0;
      end
      if (load) begin
        full <= 1'b1;
      end
    end
  end

  // Payload has no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= box_in;
    end
  end

  assign out_valid = full;
  assign box_out   = held;

endmodule

// File: hw/rtl/rre_rectangle_decoder.sv
// Top level of the RRE rectangle decoder: config registers, parser, result register.
// Depends on rre_pkg, rre_cfg_regs, rre_parser and rre_out_reg.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_ready  stream_byte
//   result    out        out_valid/out_ready  box_x box_y box_w box_h box_color
//                                             is_background last_box
//   config    in         cfg_write            cfg_index cfg_data
//
// One byte is taken per cycle while in_ready is high; a byte that completes a
// box puts it in the result register on the same edge, shown in the next cycle.
// Reset is synchronous; it clears the parser and the result valid and loads
// the register defaults. The only stall is a full result register that is
// not being drained; in_ready then drops until out_ready is seen.
module rre_rectangle_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] box_x,
  output logic [16:0] box_y,
  output logic [15:0] box_w,
  output logic [15:0] box_h,
  output logic [31:0] box_color,
  output logic        is_background,
  output logic        last_box,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rre_pkg::*;

  cfg_t cfg;
  box_t box_new;
  box_t box_held;
  logic take;
  logic emit;
  logic free;

  assign in_ready = free;
  assign take     = in_valid && free;

  rre_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rre_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .stream_byte (stream_byte),
    .emit        (emit),
    .box         (box_new)
  );

  rre_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && emit),
    .box_in    (box_new),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .box_out   (box_held)
  );

  assign box_x         = box_held.box_x;
  assign box_y         = box_held.box_y;
  assign box_w         = box_held.box_w;
  assign box_h         = box_held.box_h;
  assign box_color     = box_held.box_color;
  assign is_background = box_held.is_background;
  assign last_box      = box_held.last_box;

  // An empty result register never blocks the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the result register is empty");

  // A new result only appears after an accepted item.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted item");

  // The background box sits exactly at the rectangle origin.
  a_background_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_background |->
      box_x == {1'b0, cfg.origin_x} && box_y == {1'b0, cfg.origin_y})
    else $error("background box not at the rectangle origin");

endmodule

// File: tb/sv/rre_box_checker.sv
// Checker for the RRE rectangle decoder: watches the byte, box and register ports,
// predicts every fill-box command and compares it with what the decoder sends.
// Depends on rre_pkg for the register indexes, size codes and the box type.
`timescale 1ns / 100ps

module rre_box_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [16:0] box_x,
  input  logic [16:0] box_y,
  input  logic [15:0] box_w,
  input  logic [15:0] box_h,
  input  logic [31:0] box_color,
  input  logic        is_background,
  input  logic        last_box,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  import rre_pkg::*;

  typedef enum logic [1:0] {
    WANT_COUNT      = 2'd0,
    WANT_BACKGROUND = 2'd1,
    WANT_SUBRECT    = 2'd2
  } parse_phase_t;

  // Shadow of the decoder: registers, parser position and partial fields.
  cfg_t         cfg_shadow;
  parse_phase_t phase;
  logic [3:0]   idx;
  logic [31:0]  subrects_left;
  logic [31:0]  pix_acc;
  logic [63:0]  geom_acc;
  box_t         pending_boxes[$];

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Adds one pixel byte in the configured byte order.
  function automatic logic [31:0] merge_pixel_byte(input logic [31:0] acc,
                                                   input logic [7:0] b,
                                                   input logic [3:0] pos,
                                                   input logic msb_first);
    if (msb_first) return {acc[23:0], b};
    return acc | ({24'd0, b} << (8 * pos[1:0]));
  endfunction

  // The color is zero-extended from the current pixel size.
  function automatic logic [31:0] sized_color(input logic [31:0] acc,
                                              input int unsigned nbytes);
    if (nbytes == 1) return {24'd0, acc[7:0]};
    if (nbytes == 2) return {16'd0, acc[15:0]};
    return acc;
  endfunction

  always @(posedge clk) begin
    box_t        want;
    int unsigned nbytes;
    logic        last;
    if (rst) begin
      cfg_shadow = '0;
      cfg_shadow.pixel_size_code = PSIZE_FOUR;
      phase = WANT_COUNT;
      idx = '0;
      subrects_left = '0;
      pix_acc = '0;
      geom_acc = '0;
      pending_boxes.delete();
      mismatches = 0;
    end else begin
      // Compare each box the decoder hands over with the oldest prediction.
      if (out_valid && out_ready) begin
        if (pending_boxes.size() == 0) begin
          report_mismatch("box sent while none was predicted");
        end else begin
          want = pending_boxes.pop_front();
          check_field("box_x", 32'(box_x), 32'(want.box_x));
          check_field("box_y", 32'(box_y), 32'(want.box_y));
          check_field("box_w", 32'(box_w), 32'(want.box_w));
          check_field("box_h", 32'(box_h), 32'(want.box_h));
          check_field("box_color", box_color, want.box_color);
          check_field("is_background", 32'(is_background), 32'(want.is_background));
          check_field("last_box", 32'(last_box), 32'(want.last_box));
        end
      end

      // Advance the parser by one accepted byte; the size is read on every byte.
      if (in_valid && in_ready) begin
        case (cfg_shadow.pixel_size_code)
          PSIZE_ONE: nbytes = 1;
          PSIZE_TWO: nbytes = 2;
          default:   nbytes = 4;
        endcase
        case (phase)
          WANT_BACKGROUND: begin
            pix_acc = merge_pixel_byte(pix_acc, stream_byte, idx,
                                       cfg_shadow.pixel_msb_first);
            if (int'(idx) + 1 >= int'(nbytes)) begin
              last = (subrects_left == 0);
              want.box_x = {1'b0, cfg_shadow.origin_x};
              want.box_y = {1'b0, cfg_shadow.origin_y};
              want.box_w = cfg_shadow.area_width;
              want.box_h = cfg_shadow.area_height;
              want.box_color = sized_color(pix_acc, nbytes);
              want.is_background = 1'b1;
              want.last_box = last;
              pending_boxes.push_back(want);
              idx = '0;
              phase = last ? WANT_COUNT : WANT_SUBRECT;
              pix_acc = '0;
              geom_acc = '0;
            end else begin
              idx = idx + 4'd1;
            end
          end
          WANT_SUBRECT: begin
            // Leading bytes are the pixel, the rest shift into x, y, w, h.
            if (int'(idx) < int'(nbytes))
              pix_acc = merge_pixel_byte(pix_acc, stream_byte, idx,
                                         cfg_shadow.pixel_msb_first);
            else
              geom_acc = {geom_acc[55:0], stream_byte};
            if (int'(idx) + 1 >= int'(nbytes) + int'(GEOM_BYTES)) begin
              subrects_left = subrects_left - 32'd1;
              last = (subrects_left == 0);
              want.box_x = {1'b0, cfg_shadow.origin_x} + {1'b0, geom_acc[63:48]};
              want.box_y = {1'b0, cfg_shadow.origin_y} + {1'b0, geom_acc[47:32]};
              want.box_w = geom_acc[31:16];
              want.box_h = geom_acc[15:0];
              want.box_color = sized_color(pix_acc, nbytes);
              want.is_background = 1'b0;
              want.last_box = last;
              pending_boxes.push_back(want);
              idx = '0;
              pix_acc = '0;
              geom_acc = '0;
              if (last) phase = WANT_COUNT;
            end else begin
              idx = idx + 4'd1;
            end
          end
          default: begin
            // Big-endian subrectangle count.
            subrects_left = {subrects_left[23:0], stream_byte};
            if (int'(idx) + 1 >= int'(COUNT_BYTES)) begin
              idx = '0;
              phase = WANT_BACKGROUND;
              pix_acc = '0;
            end else begin
              idx = idx + 4'd1;
            end
          end
        endcase
      end

      // Follow the register writes; a byte taken on the same edge saw the old values.
      if (cfg_write) begin
        case (cfg_index)
          REG_PIXEL_SIZE:  cfg_shadow.pixel_size_code = cfg_data[1:0];
          REG_MSB_FIRST:   cfg_shadow.pixel_msb_first = cfg_data[0];
          REG_ORIGIN_X:    cfg_shadow.origin_x = cfg_data;
          REG_ORIGIN_Y:    cfg_shadow.origin_y = cfg_data;
          REG_AREA_WIDTH:  cfg_shadow.area_width = cfg_data;
          REG_AREA_HEIGHT: cfg_shadow.area_height = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = pending_boxes.size();
  end

endmodule

// File: tb/sv/rre_rectangle_decoder_test.sv
// Top of the RRE rectangle decoder testbench: clock, reset, byte stimulus,
// register settings, random idling and the verdict. Depends on rre_pkg, the
// decoder and rre_box_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module rre_rectangle_decoder_test;
  import rre_pkg::*;

  // Unused size code; the decoder treats it as four bytes.
  localparam logic [1:0] PSIZE_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 70;
  localparam int NO_CUT = -1;
  localparam int RANDOM_FILL = -1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  stream_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] box_x;
  logic [16:0] box_y;
  logic [15:0] box_w;
  logic [15:0] box_h;
  logic [31:0] box_color;
  logic        is_background;
  logic        last_box;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;
  int unsigned mismatches;
  int unsigned outstanding;

  // Setting that write_all_regs puts into the decoder.
  logic [1:0]  size_code;
  logic        msb_first;
  logic [15:0] org_x;
  logic [15:0] org_y;
  logic [15:0] area_w;
  logic [15:0] area_h;

  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  rre_rectangle_decoder u_dut (.*);
  rre_box_checker u_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The box receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("rre_rectangle_decoder verification failed");
      $finish;
    end
  end

  // Sends one byte after a random idle gap; returns at the accepting edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Waits until every box has come back and the parser has settled, then
  // writes all six registers.
  task automatic write_all_regs();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_PIXEL_SIZE;
    cfg_data <= {14'd0, size_code};
    @(posedge clk);
    cfg_index <= REG_MSB_FIRST;
    cfg_data <= {15'd0, msb_first};
    @(posedge clk);
    cfg_index <= REG_ORIGIN_X;
    cfg_data <= org_x;
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_data <= org_y;
    @(posedge clk);
    cfg_index <= REG_AREA_WIDTH;
    cfg_data <= area_w;
    @(posedge clk);
    cfg_index <= REG_AREA_HEIGHT;
    cfg_data <= area_h;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int item_bytes(input bit background);
    return int'(pixel_bytes(size_code)) + (background ? 0 : int'(GEOM_BYTES));
  endfunction

  // Sends one rectangle: the count, then n_items pixel items (the background
  // first). Before byte cut_at of item cut_item the pixel size changes to
  // cut_code, and the item is finished with as many bytes as the new size
  // needs. A fill below zero means random payload bytes.
  task automatic send_rect(input logic [31:0] count, input int n_items,
                           input int fill, input int cut_item, input int cut_at,
                           input logic [1:0] cut_code);
    int sent;
    logic [7:0] b;
    for (int k = 3; k >= 0; k--) send_byte(count[8*k +: 8]);
    for (int item = 0; item < n_items; item++) begin
      sent = 0;
      forever begin
        if (item == cut_item && sent == cut_at) begin
          size_code = cut_code;
          write_all_regs();
        end
        if (fill >= 0)
          b = fill[7:0];
        else if ($urandom_range(0, 9) == 0)
          b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else
          b = 8'($urandom_range(0, 255));
        send_byte(b);
        sent++;
        if (sent >= item_bytes(item == 0)) break;
      end
    end
  endtask

  initial begin
    int count;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: one-byte pixels with every geometry field at its maximum, so
    // the box corner lands past 16 bits.
    size_code = PSIZE_ONE;
    msb_first = 1'b1;
    org_x = 16'hFFFF;
    org_y = 16'hFFFF;
    area_w = 16'hFFFF;
    area_h = 16'hFFFF;
    write_all_regs();
    send_rect(32'd1, 2, 255, NO_CUT, 0, PSIZE_ONE);

    // Unused size code with a zero count: only the background box, flagged last.
    size_code = PSIZE_SPARE;
    msb_first = 1'b0;
    org_x = 16'h0000;
    org_y = 16'h0000;
    area_w = 16'h0000;
    area_h = 16'h0000;
    write_all_regs();
    send_rect(32'd0, 1, RANDOM_FILL, NO_CUT, 0, PSIZE_ONE);

    // Pixel size grows inside a subrectangle, then shrinks inside a background.
    size_code = PSIZE_TWO;
    msb_first = 1'b1;
    org_x = pick16();
    org_y = pick16();
    write_all_regs();
    send_rect(32'd1, 2, RANDOM_FILL, 1, 1, PSIZE_SPARE);
    send_rect(32'd0, 1, RANDOM_FILL, 0, 2, PSIZE_ONE);

    // Random rectangles under four idling patterns; about one in five has its
    // pixel size changed somewhere inside an item.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      size_code = 2'($urandom_range(0, 3));
      msb_first = 1'($urandom_range(0, 1));
      org_x = pick16();
      org_y = pick16();
      area_w = pick16();
      area_h = pick16();
      write_all_regs();
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) begin
        count = $urandom_range(0, 4);
        if ($urandom_range(0, 4) == 0)
          send_rect(count, count + 1, RANDOM_FILL, $urandom_range(0, count),
                    $urandom_range(0, 11), 2'($urandom_range(0, 3)));
        else
          send_rect(count, count + 1, RANDOM_FILL, NO_CUT, 0, PSIZE_ONE);
      end
    end

    // A maximal count is only counted down; the parser is left inside this
    // rectangle, so it comes last.
    send_rect(32'hFFFF_FFFF, 4, RANDOM_FILL, NO_CUT, 0, PSIZE_ONE);

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("rre_rectangle_decoder verification clean");
    else
      $display("rre_rectangle_decoder verification failed");
    $finish;
  end

endmodule
